FILE: design/fdl_pkg.sv
`default_nettype none

package fdl_pkg;

    localparam int MAX_TERMS    = 8;
    localparam int IDX_W        = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CNT_W        = $clog2(MAX_TERMS + 1);
    localparam int COEF_W       = 16;
    localparam int TRIG_W       = 16;
    localparam int PROD_W       = COEF_W + TRIG_W;
    localparam int ACC_W        = 31 + CNT_W;
    localparam int SUM_W        = 24;
    localparam int TERMS_W      = 4;
    localparam int CFG_IDX_W    = 1;

    localparam int CORDIC_STEPS = 14;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam int XY_W         = 20;
    localparam int Z_W          = 18;

    localparam logic [1:0] CMD_LOAD_DRAG = 2'd0;
    localparam logic [1:0] CMD_LOAD_LIFT = 2'd1;
    localparam logic [1:0] CMD_EVAL      = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_DRAG_TERMS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LIFT_TERMS = 1'b1;

    localparam logic [TERMS_W-1:0] TERMS_RESET = 4'd1;

    typedef struct packed {
        logic [1:0]               cmd;
        logic [2:0]               coef_index;
        logic signed [COEF_W-1:0] coef_value;
        logic signed [15:0]       angle;
    } t_in_item;

    typedef struct packed {
        logic signed [SUM_W-1:0] drag;
        logic signed [SUM_W-1:0] lift;
        logic                    saturated;
    } t_out_item;

    typedef struct packed {
        logic signed [TRIG_W-1:0] cos_v;
        logic signed [TRIG_W-1:0] sin_v;
    } t_trig;

    typedef struct packed {
        logic clr;
        logic en;
        logic sel_lift;
    } t_mac_ctl;

    typedef enum logic [1:0] {
        COR_IDLE,
        COR_RUN,
        COR_ROUND
    } t_cor_state;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_TRIG,
        ST_MUL_D,
        ST_MUL_L,
        ST_DRAIN,
        ST_FIN
    } t_state;

    // atan(2^-k) in binary-angle units, 65536 per turn
    function automatic logic signed [Z_W-1:0] atan_tab(input logic [STEP_W-1:0] k);
        logic signed [Z_W-1:0] v;
        case (k)
            4'd0:    v = 18'sd8192;
            4'd1:    v = 18'sd4836;
            4'd2:    v = 18'sd2555;
            4'd3:    v = 18'sd1297;
            4'd4:    v = 18'sd651;
            4'd5:    v = 18'sd326;
            4'd6:    v = 18'sd163;
            4'd7:    v = 18'sd81;
            4'd8:    v = 18'sd41;
            4'd9:    v = 18'sd20;
            4'd10:   v = 18'sd10;
            4'd11:   v = 18'sd5;
            4'd12:   v = 18'sd3;
            4'd13:   v = 18'sd1;
            default: v = 18'sd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: design/fdl_cordic.sv
`default_nettype none

module fdl_cordic import fdl_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [15:0] i_phase,
    output logic             o_done,
    output t_trig            o_trig
);

    localparam logic [15:0] PH_0   = 16'h0000;
    localparam logic [15:0] PH_90  = 16'h4000;
    localparam logic [15:0] PH_180 = 16'h8000;
    localparam logic [15:0] PH_270 = 16'hC000;

    localparam logic signed [XY_W-1:0]   GAIN    = 20'sd39797;
    localparam logic signed [XY_W-1:0]   XY_TWO  = 20'sd2;
    localparam logic signed [XY_W-1:0]   UNIT_XY = 20'sd16384;
    localparam logic signed [TRIG_W-1:0] UNIT    = 16'sd16384;
    localparam logic [STEP_W-1:0]        LAST    = STEP_W'(CORDIC_STEPS - 1);

    t_cor_state r_state, n_state;

    logic signed [XY_W-1:0] r_x, r_y;
    logic signed [Z_W-1:0]  r_z;
    logic [STEP_W-1:0]      r_step;
    logic                   r_flip;
    logic                   r_done;
    t_trig                  r_trig;

    logic                   w_load, w_iter, w_round;
    logic                   w_special, w_flip;
    logic [15:0]            w_zp;
    t_trig                  w_spec_trig;
    logic signed [XY_W-1:0] w_dx, w_dy, w_xs, w_ys, w_xr, w_yr;
    logic signed [TRIG_W-1:0] w_xc, w_yc;

    always_comb begin
        n_state = r_state;
        case (r_state)
            COR_IDLE:  if (i_start && !w_special) n_state = COR_RUN;
            COR_RUN:   if (r_step == LAST) n_state = COR_ROUND;
            COR_ROUND: n_state = COR_IDLE;
            default:   n_state = COR_IDLE;
        endcase
    end

    always_comb begin
        w_load  = (r_state == COR_IDLE) && i_start;
        w_iter  = (r_state == COR_RUN);
        w_round = (r_state == COR_ROUND);
    end

    // quadrant points are exact and skip the rotator
    always_comb begin
        w_special   = 1'b1;
        w_spec_trig = '0;
        case (i_phase)
            PH_0:    w_spec_trig = '{cos_v: UNIT,  sin_v: '0};
            PH_90:   w_spec_trig = '{cos_v: '0,    sin_v: UNIT};
            PH_180:  w_spec_trig = '{cos_v: -UNIT, sin_v: '0};
            PH_270:  w_spec_trig = '{cos_v: '0,    sin_v: -UNIT};
            default: w_special   = 1'b0;
        endcase
        w_flip = (i_phase >= PH_90) && (i_phase < PH_270);
        w_zp   = w_flip ? (i_phase + PH_180) : i_phase;
    end

    always_comb begin
        w_dx = r_y >>> r_step;
        w_dy = r_x >>> r_step;
        w_xs = r_x + XY_TWO;
        w_ys = r_y + XY_TWO;
        w_xr = w_xs >>> 2;
        w_yr = w_ys >>> 2;
        if (w_xr > UNIT_XY)       w_xc = UNIT;
        else if (w_xr < -UNIT_XY) w_xc = -UNIT;
        else                      w_xc = TRIG_W'(w_xr);
        if (w_yr > UNIT_XY)       w_yc = UNIT;
        else if (w_yr < -UNIT_XY) w_yc = -UNIT;
        else                      w_yc = TRIG_W'(w_yr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= COR_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (w_load && w_special) || w_round;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            if (w_special) begin
                r_trig <= w_spec_trig;
            end else begin
                r_x    <= GAIN;
                r_y    <= '0;
                r_z    <= Z_W'($signed(w_zp));
                r_flip <= w_flip;
                r_step <= '0;
            end
        end
        if (w_iter) begin
            if (!r_z[Z_W-1]) begin
                r_x <= r_x - w_dx;
                r_y <= r_y + w_dy;
                r_z <= r_z - atan_tab(r_step);
            end else begin
                r_x <= r_x + w_dx;
                r_y <= r_y - w_dy;
                r_z <= r_z + atan_tab(r_step);
            end
            r_step <= r_step + STEP_W'(1);
        end
        if (w_round) begin
            r_trig.cos_v <= r_flip ? -w_xc : w_xc;
            r_trig.sin_v <= r_flip ? -w_yc : w_yc;
        end
    end

    assign o_done = r_done;
    assign o_trig = r_trig;

endmodule

`default_nettype wire

FILE: design/fdl_mac.sv
`default_nettype none

module fdl_mac import fdl_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_mac_ctl                 i_ctl,
    input  wire logic signed [COEF_W-1:0] i_coef,
    input  wire logic signed [TRIG_W-1:0] i_trig,
    output logic signed [ACC_W-1:0]       o_drag_acc,
    output logic signed [ACC_W-1:0]       o_lift_acc
);

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_pvld;
    logic                     r_psel;
    logic signed [ACC_W-1:0]  r_dacc, r_lacc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvld <= 1'b0;
        end else begin
            r_pvld <= i_ctl.en;
        end
    end

    // product is registered, then added on the next cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_prod <= i_coef * i_trig;
            r_psel <= i_ctl.sel_lift;
        end
        if (i_ctl.clr) begin
            r_dacc <= '0;
            r_lacc <= '0;
        end else if (r_pvld) begin
            if (r_psel) r_lacc <= r_lacc + ACC_W'(r_prod);
            else        r_dacc <= r_dacc + ACC_W'(r_prod);
        end
    end

    assign o_drag_acc = r_dacc;
    assign o_lift_acc = r_lacc;

endmodule

`default_nettype wire

FILE: design/fourier_drag_lift_evaluator_unit.sv
// Evaluate item: per harmonic, one CORDIC pass of 14 rotations plus start, round and
//   drag and lift multiply states; a harmonic phase that is a quadrant point skips the
//   rotations. Harmonics = max(drag_terms, lift_terms), each clipped to MAX_TERMS.
// Load items and ignored commands are taken without leaving the idle state. One item in
//   flight at a time; the result register frees the input side while a result waits.
// Synchronous active-low reset clears control and sets both term counts to 1;
//   coefficient stores are not cleared.
`default_nettype none

module fourier_drag_lift_evaluator_unit import fdl_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in_item              i_in_item,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_item                  o_out_item,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [TERMS_W-1:0]    i_cfg_wdata
);

    localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(8192);
    localparam logic signed [ACC_W-1:0] SUM_MAX  = ACC_W'(8388607);
    localparam logic signed [ACC_W-1:0] SUM_MIN  = -ACC_W'(8388608);
    localparam int FRAC_DROP = 14;

    t_state r_state, n_state;

    logic [TERMS_W-1:0]        r_drag_terms, r_lift_terms;
    logic signed [COEF_W-1:0]  r_drag_mem [MAX_TERMS];
    logic signed [COEF_W-1:0]  r_lift_mem [MAX_TERMS];
    logic signed [COEF_W-1:0]  r_dcoef, r_lcoef;
    logic [15:0]               r_angle, r_phase;
    logic [CNT_W-1:0]          r_i, r_n, r_nd, r_nl;
    logic                      r_out_valid;
    t_out_item                 r_out_item;

    logic                      w_in_acc, w_eval, w_load_ok, w_out_free;
    logic [IDX_W-1:0]          w_widx;
    logic [CNT_W-1:0]          w_nd, w_nl, w_n;
    logic                      w_cor_start, w_cor_done;
    t_trig                     w_trig;
    t_mac_ctl                  w_mac_ctl;
    logic signed [COEF_W-1:0]  w_mac_coef;
    logic signed [TRIG_W-1:0]  w_mac_trig;
    logic signed [ACC_W-1:0]   w_dacc, w_lacc, w_dsum, w_lsum, w_dr, w_lr;
    logic signed [SUM_W-1:0]   w_dfin, w_lfin;
    logic                      w_dsat, w_lsat;

    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_eval     = w_in_acc && (i_in_item.cmd == CMD_EVAL);
    assign w_load_ok  = 32'(i_in_item.coef_index) < MAX_TERMS;
    assign w_widx     = IDX_W'(i_in_item.coef_index);
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        w_nd = (32'(r_drag_terms) > MAX_TERMS) ? CNT_W'(MAX_TERMS) : CNT_W'(r_drag_terms);
        w_nl = (32'(r_lift_terms) > MAX_TERMS) ? CNT_W'(MAX_TERMS) : CNT_W'(r_lift_terms);
        w_n  = (w_nd > w_nl) ? w_nd : w_nl;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (w_eval) n_state = (w_n == '0) ? ST_FIN : ST_START;
            ST_START: n_state = ST_TRIG;
            ST_TRIG:  if (w_cor_done) n_state = ST_MUL_D;
            ST_MUL_D: n_state = ST_MUL_L;
            ST_MUL_L: n_state = (r_i + CNT_W'(1) == r_n) ? ST_DRAIN : ST_START;
            ST_DRAIN: n_state = ST_FIN;
            ST_FIN:   if (w_out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready         = (r_state == ST_IDLE);
        w_cor_start        = (r_state == ST_START);
        w_mac_ctl.clr      = w_eval;
        w_mac_ctl.en       = ((r_state == ST_MUL_D) && (r_i < r_nd))
                          || ((r_state == ST_MUL_L) && (r_i < r_nl));
        w_mac_ctl.sel_lift = (r_state == ST_MUL_L);
        w_mac_coef         = (r_state == ST_MUL_L) ? r_lcoef : r_dcoef;
        w_mac_trig         = (r_state == ST_MUL_L) ? w_trig.sin_v : w_trig.cos_v;
    end

    fdl_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cor_start),
        .i_phase (r_phase),
        .o_done  (w_cor_done),
        .o_trig  (w_trig)
    );

    fdl_mac u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_mac_ctl),
        .i_coef     (w_mac_coef),
        .i_trig     (w_mac_trig),
        .o_drag_acc (w_dacc),
        .o_lift_acc (w_lacc)
    );

    // round once to Q11.12, then clip
    always_comb begin
        w_dsum = w_dacc + HALF_LSB;
        w_lsum = w_lacc + HALF_LSB;
        w_dr   = w_dsum >>> FRAC_DROP;
        w_lr   = w_lsum >>> FRAC_DROP;
        w_dsat = (w_dr > SUM_MAX) || (w_dr < SUM_MIN);
        w_lsat = (w_lr > SUM_MAX) || (w_lr < SUM_MIN);
        if (w_dr > SUM_MAX)      w_dfin = SUM_W'(SUM_MAX);
        else if (w_dr < SUM_MIN) w_dfin = SUM_W'(SUM_MIN);
        else                     w_dfin = SUM_W'(w_dr);
        if (w_lr > SUM_MAX)      w_lfin = SUM_W'(SUM_MAX);
        else if (w_lr < SUM_MIN) w_lfin = SUM_W'(SUM_MIN);
        else                     w_lfin = SUM_W'(w_lr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_out_valid  <= 1'b0;
            r_drag_terms <= TERMS_RESET;
            r_lift_terms <= TERMS_RESET;
        end else begin
            r_state <= n_state;
            if ((r_state == ST_FIN) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_DRAG_TERMS: r_drag_terms <= i_cfg_wdata;
                    REG_LIFT_TERMS: r_lift_terms <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_load_ok) begin
            if (i_in_item.cmd == CMD_LOAD_DRAG) r_drag_mem[w_widx] <= i_in_item.coef_value;
            if (i_in_item.cmd == CMD_LOAD_LIFT) r_lift_mem[w_widx] <= i_in_item.coef_value;
        end
        // fetch this harmonic's coefficients while the rotator runs
        if (r_state == ST_TRIG) begin
            r_dcoef <= r_drag_mem[r_i[IDX_W-1:0]];
            r_lcoef <= r_lift_mem[r_i[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_eval) begin
            r_angle <= i_in_item.angle;
            r_phase <= '0;
            r_i     <= '0;
            r_n     <= w_n;
            r_nd    <= w_nd;
            r_nl    <= w_nl;
        end else if (r_state == ST_MUL_L) begin
            r_i     <= r_i + CNT_W'(1);
            r_phase <= r_phase + r_angle;
        end
        if ((r_state == ST_FIN) && w_out_free) begin
            r_out_item.drag      <= w_dfin;
            r_out_item.lift      <= w_lfin;
            r_out_item.saturated <= w_dsat || w_lsat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_eval_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_eval |=> !o_in_ready)
        else $error("input taken right after an evaluate item");

    a_done_in_trig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cor_done |-> (r_state == ST_TRIG))
        else $error("rotator finished outside the wait state");

    a_index_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (r_i <= r_n))
        else $error("harmonic index ran past the term count");

    a_fin_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_FIN) && r_out_valid && !i_out_ready) |=> (r_state == ST_FIN))
        else $error("result dropped while output stalled");

endmodule

`default_nettype wire
